### rtl/pot_pkg.sv
// Package: shared types and constants for the plate occupancy table.
package pot_pkg;

   localparam int unsigned REGION_W     = 16;
   localparam int unsigned PLATE_W      = 56;
   localparam int unsigned MINUTES_W    = 16;
   localparam int unsigned FEE_W        = 25;
   localparam int unsigned PRICE_W      = 8;
   localparam int unsigned SPACES_W     = 9;
   localparam int unsigned SLOT_OUT_W   = 8;
   localparam int unsigned SEC_W        = 6;
   localparam int unsigned CSR_DATA_W   = 9;
   localparam int unsigned CSR_INDEX_W  = 1;

   localparam logic [SEC_W-1:0]     SEC_LAST           = SEC_W'(60 - 1);
   localparam logic [SPACES_W-1:0]  SPACES_RESET       = SPACES_W'(160);
   localparam logic [MINUTES_W-1:0] MINUTES_MAX        = '1;

   // fee = price * minutes * 5 / 3; numerator needs 27 bits, divide by three
   // through the reciprocal ceil(2^33 / 3), exact for any 32-bit numerator
   localparam int unsigned FEE_PROD_W       = PRICE_W + MINUTES_W;
   localparam int unsigned FEE_NUM_W        = FEE_PROD_W + 3;
   localparam int unsigned FEE_RECIP_SHIFT  = 33;
   localparam int unsigned FEE_SCALED_W     = FEE_RECIP_SHIFT + FEE_W;
   localparam logic [31:0] FEE_RECIP        = 32'hAAAA_AAAB;

   typedef enum logic [1:0] {
      OP_ENTER = 2'd0,
      OP_EXIT  = 2'd1,
      OP_TICK  = 2'd2,
      OP_NOP   = 2'd3
   } pot_op_type;

   typedef enum logic [2:0] {
      STS_ADMITTED  = 3'd0,
      STS_INSIDE    = 3'd1,
      STS_FULL      = 3'd2,
      STS_RELEASED  = 3'd3,
      STS_NOT_FOUND = 3'd4,
      STS_TICK      = 3'd5
   } pot_status_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PRICE  = 1'd0,
      CSR_SPACES = 1'd1
   } pot_csr_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_FEE_WAIT,
      ST_RESULT
   } pot_state_type;

   typedef enum logic [1:0] {
      FEE_IDLE,
      FEE_MUL,
      FEE_DIV
   } pot_fee_state_type;

   typedef struct packed {
      logic [1:0]          opcode;
      logic [REGION_W-1:0] region_code;
      logic [PLATE_W-1:0]  plate_chars;
   } pot_req_type;

   typedef struct packed {
      logic [2:0]            status;
      logic [SLOT_OUT_W-1:0] slot_index;
      logic [MINUTES_W-1:0]  minutes_parked;
      logic [FEE_W-1:0]      fee_hundredths;
      logic [SPACES_W-1:0]   free_spaces;
   } pot_rsp_type;

   typedef struct packed {
      logic [REGION_W-1:0] region;
      logic [PLATE_W-1:0]  plate;
   } pot_key_type;

   typedef struct packed {
      logic                 occupied;
      logic [MINUTES_W-1:0] minutes;
   } pot_entry_type;

   typedef struct packed {
      logic rd_en;
      logic key_we;
      logic entry_we;
   } pot_store_ctl_type;

endpackage

### rtl/pot_fee_unit.sv
// Fee unit: one multiply, times five, then a reciprocal multiply for the divide by three.
module pot_fee_unit
   import pot_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [PRICE_W-1:0]   price,
   input  logic [MINUTES_W-1:0] minutes,
   output logic                 done,
   output logic [FEE_W-1:0]     fee
);

   pot_fee_state_type         state_ff, state_in;
   logic [FEE_PROD_W-1:0]     prod_ff, prod_in;
   logic [FEE_NUM_W-1:0]      num_ff, num_in;
   logic [FEE_W-1:0]          fee_ff, fee_in;
   logic [FEE_SCALED_W-1:0]   scaled;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FEE_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      num_ff  <= num_in;
      fee_ff  <= fee_in;
   end

   // floor(num / 3) is the field from bit 33 up of num * ceil(2^33 / 3)
   assign scaled = num_ff * FEE_RECIP;

   always_comb begin
      state_in = state_ff;
      prod_in  = prod_ff;
      num_in   = num_ff;
      fee_in   = fee_ff;
      done     = 1'b0;
      unique case (state_ff)
         FEE_IDLE: begin
            if (start) begin
               prod_in  = FEE_PROD_W'(price * minutes);
               state_in = FEE_MUL;
            end
         end
         FEE_MUL: begin
            // times 100/60 = times 5/3
            num_in   = {prod_ff, 2'b00} + FEE_NUM_W'(prod_ff);
            state_in = FEE_DIV;
         end
         FEE_DIV: begin
            fee_in   = scaled[FEE_RECIP_SHIFT +: FEE_W];
            done     = 1'b1;
            state_in = FEE_IDLE;
         end
         default: state_in = FEE_IDLE;
      endcase
   end

   // quotient held until the next fee computation reaches its divide step
   assign fee = fee_ff;

endmodule

### rtl/pot_slot_store.sv
// Slot store: key memory and entry (occupied mark, minutes) memory.
module pot_slot_store
   import pot_pkg::*;
#(
   parameter int unsigned AW = 8
) (
   input  logic              clock,
   input  pot_store_ctl_type ctl,
   input  logic [AW-1:0]     rd_addr,
   input  logic [AW-1:0]     wr_addr,
   input  pot_key_type       wr_key,
   input  pot_entry_type     wr_entry,
   output pot_key_type       rd_key,
   output pot_entry_type     rd_entry
);

   localparam int unsigned DEPTH = 1 << AW;

   pot_key_type   key_mem   [DEPTH];
   pot_entry_type entry_mem [DEPTH];

   always_ff @(posedge clock) begin
      if (ctl.key_we) begin
         key_mem[wr_addr] <= wr_key;
      end
      if (ctl.rd_en) begin
         rd_key <= key_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.entry_we) begin
         entry_mem[wr_addr] <= wr_entry;
      end
      if (ctl.rd_en) begin
         rd_entry <= entry_mem[rd_addr];
      end
   end

endmodule

### rtl/plate_occupancy_table_with_timers.sv
// Top level: plate occupancy table with per-slot minute timers and fee output.
//
//  channel   ports                          direction  carries
//  req       req_valid/req_stall/req_data   in         enter, exit, tick or no-op
//  rsp       rsp_valid/rsp_stall/rsp_data   out        one result per request
//  csr       csr_we/csr_index/csr_wdata     in         price_per_hour, total_spaces
//
// Scan: a request scans slots 0..n-1 (n = min(total_spaces, SLOTS)) through one
//   memory read port, with a read state and a check state per slot; a match
//   ends the scan early. A release waits in ST_FEE_WAIT while the fee unit
//   multiplies and divides. Tick and no-op go straight to the result, except
//   the tick that completes a minute, which scans every slot in use.
// Reset: a clearing pass over all SLOTS entries zeroes the entry memory; req_stall is high.
// req_stall is high whenever the sequencer is busy; a result waits in the output
//   register for rsp_stall to drop while the next request may already be taken.
module plate_occupancy_table_with_timers
   import pot_pkg::*;
#(
   parameter int unsigned SLOTS = 256
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  pot_req_type            req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output pot_rsp_type            rsp_data,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   // slot address width, and scan counter width (n never exceeds 511)
   localparam int unsigned AW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int unsigned CW_RAW = $clog2(SLOTS + 1);
   localparam int unsigned CW     = (CW_RAW < SPACES_W) ? CW_RAW : SPACES_W;

   pot_state_type           state_ff, state_in;
   pot_op_type              op_ff, op_in;
   pot_key_type             key_ff, key_in;
   logic [CW-1:0]           cnt_ff, cnt_in;
   logic                    free_hit_ff, free_hit_in;
   logic [AW-1:0]           free_slot_ff, free_slot_in;
   logic [AW-1:0]           clr_addr_ff, clr_addr_in;
   pot_status_type          status_ff, status_in;
   logic [SLOT_OUT_W-1:0]   slot_ff, slot_in;
   logic [MINUTES_W-1:0]    minutes_ff, minutes_in;
   logic [SEC_W-1:0]        sec_ff, sec_in;
   logic [SPACES_W-1:0]     occ_total_ff, occ_total_in;
   logic [PRICE_W-1:0]      price_ff;
   logic [SPACES_W-1:0]     spaces_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   pot_rsp_type             rsp_data_ff, rsp_data_in;

   logic [CW-1:0]           n_slots;
   logic [SPACES_W-1:0]     n_wide;
   logic [SPACES_W-1:0]     free_now;
   logic                    key_match;

   pot_store_ctl_type       store_ctl;
   logic [AW-1:0]           rd_addr;
   logic [AW-1:0]           wr_addr;
   pot_entry_type           wr_entry;
   pot_key_type             rd_key;
   pot_entry_type           rd_entry;

   logic                    fee_start;
   logic                    fee_done;
   logic [FEE_W-1:0]        fee_value;

   pot_slot_store #(
      .AW (AW)
   ) u_store (
      .clock    (clock),
      .ctl      (store_ctl),
      .rd_addr  (rd_addr),
      .wr_addr  (wr_addr),
      .wr_key   (key_ff),
      .wr_entry (wr_entry),
      .rd_key   (rd_key),
      .rd_entry (rd_entry)
   );

   pot_fee_unit u_fee (
      .clock   (clock),
      .reset   (reset),
      .start   (fee_start),
      .price   (price_ff),
      .minutes (rd_entry.minutes),
      .done    (fee_done),
      .fee     (fee_value)
   );

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         price_ff  <= '0;
         spaces_ff <= SPACES_RESET;
      end else if (csr_we) begin
         unique case (pot_csr_type'(csr_index))
            CSR_PRICE:  price_ff  <= csr_wdata[PRICE_W-1:0];
            CSR_SPACES: spaces_ff <= csr_wdata[SPACES_W-1:0];
            default: ;
         endcase
      end
   end

   // slots in use and free count
   assign n_slots   = (32'(spaces_ff) < SLOTS) ? CW'(spaces_ff) : CW'(SLOTS);
   assign n_wide    = SPACES_W'(n_slots);
   assign free_now  = (n_wide > occ_total_ff) ? (n_wide - occ_total_ff) : '0;
   assign key_match = rd_entry.occupied && (rd_key == key_ff);

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign rd_addr   = AW'(cnt_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         sec_ff       <= '0;
         occ_total_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         sec_ff       <= sec_in;
         occ_total_ff <= occ_total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      key_ff       <= key_in;
      cnt_ff       <= cnt_in;
      free_hit_ff  <= free_hit_in;
      free_slot_ff <= free_slot_in;
      status_ff    <= status_in;
      slot_ff      <= slot_in;
      minutes_ff   <= minutes_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      cnt_in       = cnt_ff;
      free_hit_in  = free_hit_ff;
      free_slot_in = free_slot_ff;
      clr_addr_in  = clr_addr_ff;
      status_in    = status_ff;
      slot_in      = slot_ff;
      minutes_in   = minutes_ff;
      sec_in       = sec_ff;
      occ_total_in = occ_total_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      store_ctl    = '0;
      wr_addr      = AW'(cnt_ff);
      wr_entry     = '0;
      fee_start    = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            store_ctl.entry_we = 1'b1;
            wr_addr            = clr_addr_ff;
            clr_addr_in        = clr_addr_ff + 1'b1;
            if (clr_addr_ff == AW'(SLOTS - 1)) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (req_valid) begin
               op_in       = pot_op_type'(req_data.opcode);
               key_in      = {req_data.region_code, req_data.plate_chars};
               cnt_in      = '0;
               free_hit_in = 1'b0;
               status_in   = STS_TICK;
               slot_in     = '0;
               minutes_in  = '0;
               unique case (pot_op_type'(req_data.opcode))
                  OP_ENTER, OP_EXIT: state_in = ST_SCAN_RD;
                  OP_TICK: begin
                     if (sec_ff == SEC_LAST) begin
                        sec_in   = '0;
                        state_in = ST_SCAN_RD;
                     end else begin
                        sec_in   = sec_ff + 1'b1;
                        state_in = ST_RESULT;
                     end
                  end
                  OP_NOP:  state_in = ST_RESULT;
                  default: state_in = ST_RESULT;
               endcase
            end
         end

         ST_SCAN_RD: begin
            if (cnt_ff >= n_slots) begin
               // scan finished without a match
               state_in = ST_RESULT;
               case (op_ff)
                  OP_ENTER: begin
                     if (free_hit_ff) begin
                        store_ctl.key_we   = 1'b1;
                        store_ctl.entry_we = 1'b1;
                        wr_addr            = free_slot_ff;
                        wr_entry.occupied  = 1'b1;
                        occ_total_in       = occ_total_ff + 1'b1;
                        status_in          = STS_ADMITTED;
                        slot_in            = SLOT_OUT_W'(free_slot_ff);
                     end else begin
                        status_in = STS_FULL;
                     end
                  end
                  OP_EXIT: status_in = STS_NOT_FOUND;
                  default: status_in = STS_TICK;
               endcase
            end else begin
               store_ctl.rd_en = 1'b1;
               state_in        = ST_SCAN_CHK;
            end
         end

         ST_SCAN_CHK: begin
            cnt_in   = cnt_ff + 1'b1;
            state_in = ST_SCAN_RD;
            case (op_ff)
               OP_ENTER: begin
                  if (key_match) begin
                     status_in = STS_INSIDE;
                     slot_in   = SLOT_OUT_W'(cnt_ff);
                     state_in  = ST_RESULT;
                  end else if (!rd_entry.occupied && !free_hit_ff) begin
                     free_hit_in  = 1'b1;
                     free_slot_in = AW'(cnt_ff);
                  end
               end
               OP_EXIT: begin
                  if (key_match) begin
                     store_ctl.entry_we = 1'b1;
                     status_in          = STS_RELEASED;
                     slot_in            = SLOT_OUT_W'(cnt_ff);
                     minutes_in         = rd_entry.minutes;
                     fee_start          = 1'b1;
                     if (occ_total_ff != '0) begin
                        occ_total_in = occ_total_ff - 1'b1;
                     end
                     state_in = ST_FEE_WAIT;
                  end
               end
               default: begin
                  // minute roll-over: saturating increment of occupied entries
                  if (rd_entry.occupied && (rd_entry.minutes != MINUTES_MAX)) begin
                     store_ctl.entry_we = 1'b1;
                     wr_entry.occupied  = 1'b1;
                     wr_entry.minutes   = rd_entry.minutes + 1'b1;
                  end
               end
            endcase
         end

         ST_FEE_WAIT: begin
            if (fee_done) begin
               state_in = ST_RESULT;
            end
         end

         ST_RESULT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in               = 1'b1;
               rsp_data_in.status         = status_ff;
               rsp_data_in.slot_index     = slot_ff;
               rsp_data_in.minutes_parked = minutes_ff;
               rsp_data_in.fee_hundredths = (status_ff == STS_RELEASED) ? fee_value : '0;
               rsp_data_in.free_spaces    = free_now;
               state_in                   = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

endmodule

### verif/pot_occupancy_sb_pkg.sv
// Scoreboard for the plate occupancy table: parking-state predictor and result checker.
package pot_occupancy_sb_pkg;
   import pot_pkg::*;

   localparam int unsigned TABLE_SLOTS        = 256;
   localparam int unsigned SECONDS_PER_MINUTE = 60;
   localparam int unsigned HUNDREDTHS         = 100;
   localparam int unsigned MINUTES_PER_HOUR   = 60;

   class occupancy_scoreboard;
      logic [PLATE_W-1:0]   plate_at   [TABLE_SLOTS];
      logic [REGION_W-1:0]  region_at  [TABLE_SLOTS];
      bit                   parked     [TABLE_SLOTS];
      logic [MINUTES_W-1:0] minutes_at [TABLE_SLOTS];
      int unsigned          seconds;
      int unsigned          parked_total;
      logic [PRICE_W-1:0]   price;
      logic [SPACES_W-1:0]  spaces;
      pot_rsp_type          pending_outcomes[$];
      int unsigned          mismatches;

      function new();
         for (int i = 0; i < TABLE_SLOTS; i++) begin
            plate_at[i]   = '0;
            region_at[i]  = '0;
            parked[i]     = 1'b0;
            minutes_at[i] = '0;
         end
         seconds      = 0;
         parked_total = 0;
         price        = '0;
         spaces       = SPACES_RESET;
         mismatches   = 0;
      endfunction

      function void write_register(pot_csr_type idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            CSR_PRICE:  price  = value[PRICE_W-1:0];
            CSR_SPACES: spaces = value[SPACES_W-1:0];
            default: ;
         endcase
      endfunction

      function int unsigned spaces_in_use();
         if (int'(spaces) > int'(TABLE_SLOTS)) return TABLE_SLOTS;
         return 32'(spaces);
      endfunction

      // only slots below the spaces in use are searched
      function int find_parked(logic [REGION_W-1:0] region, logic [PLATE_W-1:0] plate);
         int unsigned n;
         n = spaces_in_use();
         for (int i = 0; i < n; i++) begin
            if (parked[i] && region_at[i] == region && plate_at[i] == plate) return i;
         end
         return -1;
      endfunction

      // note an accepted request: advance the parking state and queue its outcome
      function void note_request(pot_req_type r);
         pot_rsp_type     outcome;
         int unsigned     n;
         int              hit;
         longint unsigned fee;
         n = spaces_in_use();
         outcome = '0;
         outcome.status = STS_TICK;
         case (r.opcode)
            OP_ENTER: begin
               hit = find_parked(r.region_code, r.plate_chars);
               if (hit >= 0) begin
                  outcome.status     = STS_INSIDE;
                  outcome.slot_index = SLOT_OUT_W'(hit);
               end else begin
                  outcome.status = STS_FULL;
                  for (int i = 0; i < n; i++) begin
                     if (!parked[i]) begin
                        plate_at[i]        = r.plate_chars;
                        region_at[i]       = r.region_code;
                        parked[i]          = 1'b1;
                        minutes_at[i]      = '0;
                        parked_total++;
                        outcome.status     = STS_ADMITTED;
                        outcome.slot_index = SLOT_OUT_W'(i);
                        break;
                     end
                  end
               end
            end
            OP_EXIT: begin
               hit = find_parked(r.region_code, r.plate_chars);
               if (hit >= 0) begin
                  fee = (64'(price) * 64'(minutes_at[hit]) * HUNDREDTHS) / MINUTES_PER_HOUR;
                  outcome.status         = STS_RELEASED;
                  outcome.slot_index     = SLOT_OUT_W'(hit);
                  outcome.minutes_parked = minutes_at[hit];
                  outcome.fee_hundredths = FEE_W'(fee);
                  parked[hit]     = 1'b0;
                  minutes_at[hit] = '0;
                  if (parked_total > 0) parked_total--;
               end else begin
                  outcome.status = STS_NOT_FOUND;
               end
            end
            OP_TICK: begin
               seconds++;
               if (seconds >= SECONDS_PER_MINUTE) begin
                  seconds = 0;
                  for (int i = 0; i < n; i++) begin
                     if (parked[i] && minutes_at[i] != MINUTES_MAX) minutes_at[i]++;
                  end
               end
            end
            default: ;
         endcase
         outcome.free_spaces = (n > parked_total) ? SPACES_W'(n - parked_total) : '0;
         pending_outcomes.push_back(outcome);
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
         end
      endfunction

      function void check_response(pot_rsp_type got);
         pot_rsp_type want;
         if (pending_outcomes.size() == 0) begin
            $display("%0t: result with none outstanding, expected nothing, actual %h",
                     $time, got);
            mismatches++;
            return;
         end
         want = pending_outcomes.pop_front();
         compare_field("status", 32'(want.status), 32'(got.status));
         compare_field("slot_index", 32'(want.slot_index), 32'(got.slot_index));
         compare_field("minutes_parked", 32'(want.minutes_parked),
                       32'(got.minutes_parked));
         compare_field("fee_hundredths", 32'(want.fee_hundredths),
                       32'(got.fee_hundredths));
         compare_field("free_spaces", 32'(want.free_spaces), 32'(got.free_spaces));
      endfunction

      function bit all_delivered();
         return pending_outcomes.size() == 0;
      endfunction

      // random key of a car currently parked anywhere in the table
      function bit pick_parked(output pot_key_type key);
         int slots[$];
         int pick;
         key = '0;
         for (int i = 0; i < TABLE_SLOTS; i++) begin
            if (parked[i]) slots.push_back(i);
         end
         if (slots.size() == 0) return 1'b0;
         pick = slots[$urandom_range(0, slots.size() - 1)];
         key.region = region_at[pick];
         key.plate  = plate_at[pick];
         return 1'b1;
      endfunction

      function bit passed();
         if (pending_outcomes.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, pending_outcomes.size());
         end
         return mismatches == 0 && pending_outcomes.size() == 0;
      endfunction
   endclass

endpackage

### verif/tb_plate_occupancy_table_with_timers.sv
// Testbench top: drives requests and register writes into the occupancy table, checks results.
module tb_plate_occupancy_table_with_timers;
   timeunit 1ns;
   timeprecision 1ps;
   import pot_pkg::*;
   import pot_occupancy_sb_pkg::*;

   // longest quiet stretch: a full 256-slot scan plus the fee divide, a long
   // sender gap and a long stall; the limit leaves a wide margin over that
   localparam int unsigned WATCHDOG_LIMIT = 20000;
   localparam int unsigned SETTLE_CYCLES  = 600;
   localparam int unsigned KEY_POOL       = 24;
   localparam int unsigned PHASES         = 9;
   localparam int          PRICE_RANDOM   = -1;

   // directed keys: all ones, all zeros and a few ordinary plates
   localparam logic [REGION_W-1:0] REGION_C = 16'h4E59;
   localparam logic [PLATE_W-1:0]  PLATE_C  = 56'h41_42_31_32_33_34_35;
   localparam logic [REGION_W-1:0] REGION_D = 16'h5348;
   localparam logic [PLATE_W-1:0]  PLATE_D  = 56'h43_44_39_38_37_36_35;
   localparam logic [REGION_W-1:0] REGION_E = 16'h8001;
   localparam logic [PLATE_W-1:0]  PLATE_E  = 56'h80_00_00_00_00_00_01;
   localparam logic [REGION_W-1:0] REGION_F = 16'h1234;
   localparam logic [PLATE_W-1:0]  PLATE_F  = 56'h55_AA_55_AA_55_AA_55;

   // random phases: price, spaces in use and request count
   int phase_price  [PHASES] = '{0, 255, PRICE_RANDOM, PRICE_RANDOM, PRICE_RANDOM,
                                 255, PRICE_RANDOM, 128, PRICE_RANDOM};
   int phase_spaces [PHASES] = '{160, 8, 256, 1, 32, 0, 16, 256, 100};
   int phase_items  [PHASES] = '{180, 180, 70, 100, 200, 40, 200, 60, 100};

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   pot_req_type            req_data;
   logic                   rsp_valid;
   logic                   rsp_stall;
   pot_rsp_type            rsp_data;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   bit                     idling = 1'b0;
   int unsigned            quiet_cycles = 0;
   pot_key_type            key_pool [KEY_POOL];
   occupancy_scoreboard    sb;

   plate_occupancy_table_with_timers #(
      .SLOTS (TABLE_SLOTS)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // 20 ns period
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // result side, when idling: open and stalled stretches, mostly short, now and then long
   initial begin : stall_driver
      int unsigned open_len;
      int unsigned hold_len;
      rsp_stall = 1'b0;
      forever begin
         if (!idling) begin
            @(negedge clock) rsp_stall <= 1'b0;
         end else begin
            open_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            hold_len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50)
                                                   : $urandom_range(1, 3);
            repeat (open_len) @(negedge clock) rsp_stall <= 1'b0;
            repeat (hold_len) @(negedge clock) rsp_stall <= 1'b1;
         end
      end
   end

   // every result taken at a rising edge is checked against the oldest outcome
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) sb.check_response(rsp_data);
   end

   // watchdog: ends the run after too long without any handshake
   always @(posedge clock) begin
      if ((req_valid === 1'b1 && req_stall === 1'b0) ||
          (rsp_valid === 1'b1 && rsp_stall === 1'b0)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
         $display("CHECK FAILED");
         $finish;
      end
   end

   // present one request, optionally after a gap, and hold it until taken
   task automatic send_request(input pot_req_type r);
      int unsigned gap;
      gap = 0;
      if (idling && $urandom_range(0, 9) >= 6) begin
         gap = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
      end
      if (gap > 0) begin
         @(negedge clock) req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall !== 1'b0);
      sb.note_request(r);
   endtask

   task automatic send_fields(input pot_op_type op, input logic [REGION_W-1:0] region,
                              input logic [PLATE_W-1:0] plate);
      pot_req_type r;
      r.opcode      = op;
      r.region_code = region;
      r.plate_chars = plate;
      send_request(r);
   endtask

   // sender holds off until every outstanding result has come back
   task automatic drain_results();
      @(negedge clock) req_valid <= 1'b0;
      while (!sb.all_delivered()) @(posedge clock);
   endtask

   task automatic write_register(input pot_csr_type idx, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock) csr_we <= 1'b0;
      sb.write_register(idx, value);
   endtask

   // registers are only touched with the table idle
   task automatic reconfigure(input logic [PRICE_W-1:0] price,
                              input logic [SPACES_W-1:0] spaces);
      drain_results();
      write_register(CSR_PRICE, CSR_DATA_W'(price));
      write_register(CSR_SPACES, CSR_DATA_W'(spaces));
   endtask

   // Random request mix: ticks so that timers advance, enters mostly from a
   // small pool of plates (repeat arrivals), exits mostly of parked cars.
   // Near-miss exits flip one key bit to exercise the full 72-bit compare.
   task automatic random_request(output pot_req_type r);
      int unsigned          roll;
      int unsigned          sub;
      int unsigned          pos;
      pot_key_type          key;
      logic [REGION_W+PLATE_W-1:0] flat;
      r.region_code = REGION_W'($urandom());
      r.plate_chars = PLATE_W'({$urandom(), $urandom()});
      roll = $urandom_range(0, 99);
      sub  = $urandom_range(0, 9);
      if (roll < 35) begin
         r.opcode = OP_TICK;
      end else if (roll < 38) begin
         r.opcode = OP_NOP;
      end else if (roll < 70) begin
         r.opcode = OP_ENTER;
         if (sub < 6) begin
            key           = key_pool[$urandom_range(0, KEY_POOL - 1)];
            r.region_code = key.region;
            r.plate_chars = key.plate;
         end
      end else begin
         r.opcode = OP_EXIT;
         if (sub < 6 || sub == 8) begin
            if (sb.pick_parked(key)) begin
               if (sub == 8) begin
                  flat      = key;
                  pos       = $urandom_range(0, REGION_W + PLATE_W - 1);
                  flat[pos] = ~flat[pos];
                  key       = flat;
               end
               r.region_code = key.region;
               r.plate_chars = key.plate;
            end
         end else if (sub < 8) begin
            key           = key_pool[$urandom_range(0, KEY_POOL - 1)];
            r.region_code = key.region;
            r.plate_chars = key.plate;
         end
      end
   endtask

   initial begin : stimulus
      pot_req_type        r;
      logic [PRICE_W-1:0] price;
      sb        = new();
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_we    = 1'b0;
      csr_index = CSR_PRICE;
      csr_wdata = '0;
      idling    = 1'b1;
      foreach (key_pool[k]) begin
         key_pool[k].region = REGION_W'($urandom());
         key_pool[k].plate  = PLATE_W'({$urandom(), $urandom()});
      end

      repeat (4) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      // the clearing pass keeps req_stall high
      do @(posedge clock); while (req_stall !== 1'b0);

      // directed: four spaces, top price
      reconfigure(8'd255, 9'd4);
      send_fields(OP_EXIT, '1, '1);                  // empty table, unknown plate
      send_fields(OP_ENTER, '1, '1);                 // slot 0
      send_fields(OP_ENTER, '0, '0);                 // slot 1
      send_fields(OP_ENTER, '1, '1);                 // already inside
      send_fields(OP_ENTER, REGION_C, PLATE_C);
      send_fields(OP_ENTER, REGION_D, PLATE_D);
      send_fields(OP_ENTER, REGION_E, PLATE_E);      // table full
      send_fields(OP_EXIT, '0, '0);                  // release with no minutes
      send_fields(OP_ENTER, REGION_E, PLATE_E);      // reuses the freed slot
      send_fields(OP_EXIT, 16'hFFFE, '1);            // region one bit off
      send_fields(OP_EXIT, '1, 56'h7F_FFFF_FFFF_FFFF); // top plate bit off
      send_fields(OP_NOP, '1, '1);
      send_fields(OP_TICK, '0, '0);

      // shrink below the occupied slots: those above stay parked but unseen
      reconfigure(8'd255, 9'd2);
      send_fields(OP_EXIT, REGION_C, PLATE_C);       // beyond the spaces in use
      send_fields(OP_ENTER, REGION_F, PLATE_F);      // full, free count clamps
      send_fields(OP_TICK, '1, '1);

      // no spaces at all
      reconfigure(8'd0, 9'd0);
      send_fields(OP_ENTER, REGION_F, PLATE_F);
      send_fields(OP_EXIT, '1, '1);
      send_fields(OP_TICK, '0, '0);

      // grow back: the hidden cars become reachable again
      reconfigure(8'd255, 9'd4);
      send_fields(OP_EXIT, REGION_C, PLATE_C);
      send_fields(OP_EXIT, REGION_D, PLATE_D);

      // random phases; cars carry their minutes from one phase to the next
      foreach (phase_items[p]) begin
         idling = (p % 3) != 0;
         price  = (phase_price[p] == PRICE_RANDOM) ? PRICE_W'($urandom_range(1, 254))
                                                   : PRICE_W'(phase_price[p]);
         reconfigure(price, SPACES_W'(phase_spaces[p]));
         repeat (phase_items[p]) begin
            random_request(r);
            send_request(r);
         end
      end

      drain_results();
      // room for any stray result to show up
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.passed()) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
